[hdl/acp_pkg.sv]
// Shared types, codes and helpers for the ANSI escape console parser.
`default_nettype none

package acp_pkg;

    // Width of the cursor move count
    localparam int COUNT_BITS = 12;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Attribute after reset and after "ESC [ 0 m": white on black
    localparam logic [7:0] ATTR_DEFAULT = 8'h0F;

    // Byte codes the parser looks for
    localparam logic [7:0] ASC_ESC      = 8'h1B;
    localparam logic [7:0] ASC_LBRACKET = 8'h5B;
    localparam logic [7:0] ASC_QUESTION = 8'h3F;
    localparam logic [7:0] ASC_ZERO     = 8'h30;
    localparam logic [7:0] ASC_TWO      = 8'h32;
    localparam logic [7:0] ASC_THREE    = 8'h33;
    localparam logic [7:0] ASC_FOUR     = 8'h34;
    localparam logic [7:0] ASC_SIX      = 8'h36;
    localparam logic [7:0] ASC_NINE     = 8'h39;
    localparam logic [7:0] ASC_UP_A     = 8'h41;
    localparam logic [7:0] ASC_UP_B     = 8'h42;
    localparam logic [7:0] ASC_UP_C     = 8'h43;
    localparam logic [7:0] ASC_UP_D     = 8'h44;
    localparam logic [7:0] ASC_UP_H     = 8'h48;
    localparam logic [7:0] ASC_UP_J     = 8'h4A;
    localparam logic [7:0] ASC_UP_K     = 8'h4B;
    localparam logic [7:0] ASC_LO_H     = 8'h68;
    localparam logic [7:0] ASC_LO_L     = 8'h6C;
    localparam logic [7:0] ASC_LO_M     = 8'h6D;
    localparam logic [7:0] ASC_LO_S     = 8'h73;
    localparam logic [7:0] ASC_LO_U     = 8'h75;

    // Parameter bytes span 0x30..0x3F
    localparam logic [3:0] PARAM_HI_NIBBLE = 4'h3;

    // Saturation point of the parameter length
    localparam logic [2:0] LEN_MAX = 3'd7;

    // Blink sequence "?25": three bytes, digit value 25
    localparam logic [2:0]            BLINK_LEN   = 3'd3;
    localparam logic [COUNT_BITS-1:0] BLINK_VALUE = COUNT_BITS'(25);

    typedef enum logic [3:0] {
        CMD_PRINT     = 4'd0,
        CMD_UP        = 4'd1,
        CMD_DOWN      = 4'd2,
        CMD_RIGHT     = 4'd3,
        CMD_LEFT      = 4'd4,
        CMD_HOME      = 4'd5,
        CMD_CLEAR     = 4'd6,
        CMD_SAVE      = 4'd7,
        CMD_RESTORE   = 4'd8,
        CMD_ERASE     = 4'd9,
        CMD_BLINK_ON  = 4'd10,
        CMD_BLINK_OFF = 4'd11
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       first;
        logic [7:0] start_color;
    } in_item_t;

    typedef struct packed {
        cmd_t                  command;
        logic [7:0]            glyph;
        logic [7:0]            attribute;
        logic [COUNT_BITS-1:0] move_count;
    } out_item_t;

    // Collected parameters of the open control sequence
    typedef struct packed {
        logic [7:0]            lead;
        logic [7:0]            second;
        logic [2:0]            len;
        logic [COUNT_BITS-1:0] acc;
        logic                  tail_digits;
    } seq_ctx_t;

    // Verdict on a finished control sequence
    typedef struct packed {
        logic                  fire;
        cmd_t                  command;
        logic [COUNT_BITS-1:0] count;
        logic [7:0]            attr;
    } seq_dec_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= ASC_ZERO) && (b <= ASC_NINE);
    endfunction

    // SGR digit to 3-bit color code
    function automatic logic [2:0] color_code(input logic [7:0] d);
        logic [2:0] n;
        n = 3'd7;
        if (d >= ASC_ZERO && d <= ASC_SIX) begin
            case (d[2:0])
                3'd0:    n = 3'd0;
                3'd1:    n = 3'd4;
                3'd2:    n = 3'd2;
                3'd3:    n = 3'd6;
                3'd4:    n = 3'd1;
                3'd5:    n = 3'd5;
                3'd6:    n = 3'd3;
                default: n = 3'd7;
            endcase
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[hdl/acp_seq_decode.sv]
// Decoder for a finished control sequence: command, count and new attribute.
`default_nettype none

module acp_seq_decode
    import acp_pkg::*;
(
    input  wire logic [7:0] final_byte,
    input  wire seq_ctx_t   ctx,
    input  wire logic [7:0] attr,
    output seq_dec_t        dec
);

    logic [2:0] color;
    logic       lead_digit;

    assign color      = color_code(ctx.second);
    assign lead_digit = is_digit(ctx.lead);

    always_comb
    begin
        dec.fire    = 1'b0;
        dec.command = CMD_PRINT;
        dec.count   = '0;
        dec.attr    = attr;

        // Bare single-letter sequences
        if (ctx.len == 3'd0 && (final_byte == ASC_LO_S || final_byte == ASC_LO_U ||
                                final_byte == ASC_UP_K || final_byte == ASC_UP_H)) begin
            dec.fire = 1'b1;
            unique case (final_byte)
                ASC_LO_S: dec.command = CMD_SAVE;
                ASC_LO_U: dec.command = CMD_RESTORE;
                ASC_UP_K: dec.command = CMD_ERASE;
                default:  dec.command = CMD_HOME;
            endcase
        end
        // Cursor moves with an optional decimal count
        else if (final_byte >= ASC_UP_A && final_byte <= ASC_UP_D && ctx.tail_digits &&
                 (ctx.len == 3'd0 || lead_digit)) begin
            dec.fire  = 1'b1;
            dec.count = ctx.acc;
            unique case (final_byte)
                ASC_UP_A: dec.command = CMD_UP;
                ASC_UP_B: dec.command = CMD_DOWN;
                ASC_UP_C: dec.command = CMD_RIGHT;
                default:  dec.command = CMD_LEFT;
            endcase
        end
        // "?25" blink control; other finals drop it
        else if (ctx.len == BLINK_LEN && ctx.lead == ASC_QUESTION && ctx.tail_digits &&
                 ctx.acc == BLINK_VALUE) begin
            if (final_byte == ASC_LO_L) begin
                dec.fire    = 1'b1;
                dec.command = CMD_BLINK_ON;
            end
            else if (final_byte == ASC_LO_H) begin
                dec.fire    = 1'b1;
                dec.command = CMD_BLINK_OFF;
            end
        end
        // Two-byte color select, no output
        else if (ctx.len == 3'd2 && final_byte == ASC_LO_M &&
                 (ctx.lead == ASC_THREE || ctx.lead == ASC_NINE || ctx.lead == ASC_FOUR)) begin
            case (ctx.lead)
                ASC_THREE: dec.attr = {attr[7:4], 1'b0, color};
                ASC_NINE:  dec.attr = {attr[7:4], 1'b1, color};
                default:   dec.attr = {1'b0, color, attr[3:0]};
            endcase
        end
        // Color reset
        else if (ctx.len == 3'd1 && ctx.lead == ASC_ZERO && final_byte == ASC_LO_M) begin
            dec.attr = ATTR_DEFAULT;
        end
        // Clear screen
        else if (ctx.len == 3'd1 && ctx.lead == ASC_TWO && final_byte == ASC_UP_J) begin
            dec.fire    = 1'b1;
            dec.command = CMD_CLEAR;
        end
    end

endmodule

`default_nettype wire

[hdl/ansi_escape_console_parser.sv]
// Top level: ANSI escape console parser with input and result registers.
//
//  Channel  Handshake               Payload      Direction
//  byte     byte_valid/byte_stall   in_item_t    in: console text, one byte per item
//  cmd      cmd_valid/cmd_stall     out_item_t   out: print and cursor commands
//
//  One byte item per cycle unless cmd stalls; cmd_valid comes from the result register.
//  The parse state updates as an item moves from the input register to the result register.
//  Bytes that only change state (escape prefixes, parameters, colors) give no result item.
//  A stall on cmd holds the result register and, through it, the input register.
//  rst_n clears the attribute to white on black and the parser to plain text.
`default_nettype none

module ansi_escape_console_parser
    import acp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_stall,
    input  wire in_item_t  byte_item,
    output logic           cmd_valid,
    input  wire logic      cmd_stall,
    output out_item_t      cmd_item
);

    localparam int ACC_W = COUNT_BITS + 4;

    // Input register
    logic      hold_valid_reg;
    in_item_t  hold_reg;

    // Result register
    logic      out_valid_reg;
    out_item_t out_reg;

    // Parse state
    logic [7:0]            attr_reg,   attr_next;
    phase_t                phase_reg,  phase_next;
    logic [7:0]            lead_reg,   lead_next;
    logic [7:0]            second_reg, second_next;
    logic [2:0]            len_reg,    len_next;
    logic [COUNT_BITS-1:0] acc_reg,    acc_next;
    logic                  tail_reg,   tail_next;

    logic       advance;
    logic       emit;
    out_item_t  emit_item;
    logic [7:0] attr_cur;
    phase_t     phase_cur;
    logic [7:0] b;
    logic       b_digit;
    logic [ACC_W-1:0] acc_ext;
    logic [ACC_W-1:0] acc_sum;
    seq_ctx_t   ctx;
    seq_dec_t   dec;

    // Handshake
    assign advance    = hold_valid_reg && (!out_valid_reg || !cmd_stall);
    assign byte_stall = hold_valid_reg && !advance;
    assign cmd_valid  = out_valid_reg;
    assign cmd_item   = out_reg;

    // Decimal accumulate: acc*10 + digit, saturating
    assign b       = hold_reg.text_byte;
    assign b_digit = is_digit(b);
    assign acc_ext = ACC_W'(acc_reg);
    assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(b[3:0]);

    assign attr_cur  = hold_reg.first ? hold_reg.start_color : attr_reg;
    assign phase_cur = hold_reg.first ? PH_IDLE : phase_reg;

    assign ctx = '{lead: lead_reg, second: second_reg, len: len_reg,
                   acc: acc_reg, tail_digits: tail_reg};

    acp_seq_decode u_decode (
        .final_byte (b),
        .ctx        (ctx),
        .attr       (attr_cur),
        .dec        (dec)
    );

    // Next parse state and result
    always_comb
    begin
        attr_next   = attr_cur;
        phase_next  = phase_cur;
        lead_next   = lead_reg;
        second_next = second_reg;
        len_next    = len_reg;
        acc_next    = acc_reg;
        tail_next   = tail_reg;
        emit        = 1'b0;
        emit_item   = '{command: CMD_PRINT, glyph: 8'h00, attribute: attr_cur,
                        move_count: '0};

        unique case (phase_cur)
            PH_ESC:
            begin
                if (b == ASC_LBRACKET) begin
                    phase_next  = PH_CSI;
                    lead_next   = 8'h00;
                    second_next = 8'h00;
                    len_next    = 3'd0;
                    acc_next    = '0;
                    tail_next   = 1'b1;
                end
                else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_CSI:
            begin
                if (b[7:4] == PARAM_HI_NIBBLE) begin
                    if (len_reg == 3'd0) begin
                        lead_next = b;
                    end
                    else begin
                        if (len_reg == 3'd1) begin
                            second_next = b;
                        end
                        if (!b_digit) begin
                            tail_next = 1'b0;
                        end
                    end
                    if (len_reg != LEN_MAX) begin
                        len_next = len_reg + 3'd1;
                    end
                    if (b_digit) begin
                        acc_next = (acc_sum > ACC_W'(COUNT_MAX)) ? COUNT_MAX
                                                                 : acc_sum[COUNT_BITS-1:0];
                    end
                end
                else if (b == ASC_ESC) begin
                    phase_next = PH_ESC;
                end
                else begin
                    phase_next = PH_IDLE;
                    attr_next  = dec.attr;
                    emit       = dec.fire;
                    emit_item  = '{command: dec.command, glyph: 8'h00, attribute: attr_cur,
                                   move_count: dec.count};
                end
            end
            default:
            begin
                // Plain text, also for the unused phase code
                if (b == ASC_ESC) begin
                    phase_next = PH_ESC;
                end
                else begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    emit_item  = '{command: CMD_PRINT, glyph: b, attribute: attr_cur,
                                   move_count: '0};
                end
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            attr_reg       <= ATTR_DEFAULT;
            phase_reg      <= PH_IDLE;
            lead_reg       <= 8'h00;
            second_reg     <= 8'h00;
            len_reg        <= 3'd0;
            acc_reg        <= '0;
            tail_reg       <= 1'b1;
        end
        else begin
            if (!byte_stall) begin
                hold_valid_reg <= byte_valid;
            end
            if (advance) begin
                out_valid_reg <= emit;
                attr_reg      <= attr_next;
                phase_reg     <= phase_next;
                lead_reg      <= lead_next;
                second_reg    <= second_next;
                len_reg       <= len_next;
                acc_reg       <= acc_next;
                tail_reg      <= tail_next;
            end
            else if (!cmd_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall) begin
            hold_reg <= byte_item;
        end
        if (advance && emit) begin
            out_reg <= emit_item;
        end
    end

    // A byte that yields a command shows it in the next cycle
    a_emit_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> cmd_valid)
        else $error("result lost after emit");

    // A held input byte stays until it moves on
    a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !advance) |=> hold_valid_reg)
        else $error("held byte dropped");

    // Only print commands carry a glyph
    a_glyph_print: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_item.command != CMD_PRINT) |-> (cmd_item.glyph == 8'h00))
        else $error("glyph on non-print command");

    // Only cursor moves carry a count
    a_count_move: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_item.move_count != '0) |->
            (cmd_item.command == CMD_UP || cmd_item.command == CMD_DOWN ||
             cmd_item.command == CMD_RIGHT || cmd_item.command == CMD_LEFT))
        else $error("count on non-move command");

endmodule

`default_nettype wire

[dv/console_cmd_checker.sv]
// Command checker for the console parser: predicts command items from accepted bytes and compares.
`default_nettype none

module console_cmd_checker
    import acp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    input  wire logic      byte_stall,
    input  wire in_item_t  byte_item,
    input  wire logic      cmd_valid,
    input  wire logic      cmd_stall,
    input  wire out_item_t cmd_item,
    output int             failures,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // Commands predicted but not yet seen on the cmd channel
    out_item_t expected_cmds[$];
    int        errors;

    // Shadow parser state
    logic [7:0]            attr_r;
    phase_t                phase_r;
    logic [7:0]            lead_r;
    logic [7:0]            second_r;
    logic [2:0]            len_r;
    logic [COUNT_BITS-1:0] acc_r;
    logic                  digits_only_r;

    function automatic logic decimal_byte(input logic [7:0] b);
        return (b >= ASC_ZERO) && (b <= ASC_NINE);
    endfunction

    task automatic clear_params();
        lead_r        = '0;
        second_r      = '0;
        len_r         = '0;
        acc_r         = '0;
        digits_only_r = 1'b1;
    endtask

    task automatic expect_cmd(input cmd_t c, input logic [7:0] g,
                              input logic [COUNT_BITS-1:0] cnt);
        out_item_t r;
        r.command    = c;
        r.glyph      = g;
        r.attribute  = attr_r;
        r.move_count = cnt;
        expected_cmds.push_back(r);
    endtask

    // Decide on a sequence closed by final byte f
    task automatic close_sequence(input logic [7:0] f);
        logic [2:0] n;
        logic [3:0] fg;
        logic [3:0] bg;
        if (len_r == 0 && f == ASC_LO_S)
            expect_cmd(CMD_SAVE, 8'h00, '0);
        else if (len_r == 0 && f == ASC_LO_U)
            expect_cmd(CMD_RESTORE, 8'h00, '0);
        else if (len_r == 0 && f == ASC_UP_K)
            expect_cmd(CMD_ERASE, 8'h00, '0);
        else if (len_r == 0 && f == ASC_UP_H)
            expect_cmd(CMD_HOME, 8'h00, '0);
        else if (f >= ASC_UP_A && f <= ASC_UP_D && digits_only_r
                 && (len_r == 0 || decimal_byte(lead_r)))
        begin
            expect_cmd(cmd_t'(CMD_UP + (f - ASC_UP_A)), 8'h00, acc_r);
        end
        else if (len_r == BLINK_LEN && lead_r == ASC_QUESTION && digits_only_r
                 && acc_r == BLINK_VALUE)
        begin
            if (f == ASC_LO_L)
                expect_cmd(CMD_BLINK_ON, 8'h00, '0);
            else if (f == ASC_LO_H)
                expect_cmd(CMD_BLINK_OFF, 8'h00, '0);
        end
        else if (len_r == 2 && f == ASC_LO_M
                 && (lead_r == ASC_THREE || lead_r == ASC_NINE || lead_r == ASC_FOUR))
        begin
            // ANSI digit order to the attribute's color order
            case (second_r)
                ASC_ZERO:       n = 3'd0;
                ASC_ZERO + 1:   n = 3'd4;
                ASC_TWO:        n = 3'd2;
                ASC_THREE:      n = 3'd6;
                ASC_FOUR:       n = 3'd1;
                ASC_ZERO + 5:   n = 3'd5;
                ASC_SIX:        n = 3'd3;
                default:        n = 3'd7;
            endcase
            fg = attr_r[3:0];
            bg = attr_r[7:4];
            if (lead_r == ASC_THREE)
                fg = {1'b0, n};
            else if (lead_r == ASC_NINE)
                fg = {1'b1, n};
            else
                bg = {1'b0, n};
            attr_r = {bg, fg};
        end
        else if (len_r == 1 && lead_r == ASC_ZERO && f == ASC_LO_M)
            attr_r = ATTR_DEFAULT;
        else if (len_r == 1 && lead_r == ASC_TWO && f == ASC_UP_J)
            expect_cmd(CMD_CLEAR, 8'h00, '0);
    endtask

    // Advance the shadow parser by one accepted byte
    task automatic parse_byte(input in_item_t it);
        logic [7:0] b;
        int         d;
        b = it.text_byte;
        if (it.first)
        begin
            attr_r  = it.start_color;
            phase_r = PH_IDLE;
        end
        case (phase_r)
            PH_ESC:
            begin
                if (b == ASC_LBRACKET)
                begin
                    phase_r = PH_CSI;
                    clear_params();
                end
                else
                    phase_r = PH_IDLE;
            end
            PH_CSI:
            begin
                if (b[7:4] == PARAM_HI_NIBBLE)
                begin
                    if (len_r == 0)
                        lead_r = b;
                    else
                    begin
                        if (len_r == 1)
                            second_r = b;
                        if (!decimal_byte(b))
                            digits_only_r = 1'b0;
                    end
                    if (len_r != LEN_MAX)
                        len_r = len_r + 3'd1;
                    if (decimal_byte(b))
                    begin
                        d = int'(b - ASC_ZERO);
                        if (int'(acc_r) > (int'(COUNT_MAX) - d) / 10)
                            acc_r = COUNT_MAX;
                        else
                            acc_r = COUNT_BITS'(int'(acc_r) * 10 + d);
                    end
                end
                else if (b == ASC_ESC)
                    phase_r = PH_ESC;
                else
                begin
                    phase_r = PH_IDLE;
                    close_sequence(b);
                end
            end
            default:
            begin
                if (b == ASC_ESC)
                    phase_r = PH_ESC;
                else
                begin
                    phase_r = PH_IDLE;
                    expect_cmd(CMD_PRINT, b, '0);
                end
            end
        endcase
    endtask

    task automatic check_cmd(input out_item_t got);
        out_item_t want;
        if (expected_cmds.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: cmd item with none expected: cmd=%0d glyph=%h attr=%h count=%0d",
                         $realtime, got.command, got.glyph, got.attribute, got.move_count);
            return;
        end
        want = expected_cmds.pop_front();
        if (got.command !== want.command || got.glyph !== want.glyph
            || got.attribute !== want.attribute || got.move_count !== want.move_count)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display({"%0t: cmd mismatch: exp cmd=%0d glyph=%h attr=%h count=%0d,",
                          " got cmd=%0d glyph=%h attr=%h count=%0d"},
                         $realtime, want.command, want.glyph, want.attribute, want.move_count,
                         got.command, got.glyph, got.attribute, got.move_count);
        end
    endtask

    // Check results first, then predict from the byte taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_r  = ATTR_DEFAULT;
            phase_r = PH_IDLE;
            clear_params();
            expected_cmds.delete();
            errors  = 0;
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
                check_cmd(cmd_item);
            if (byte_valid && !byte_stall)
                parse_byte(byte_item);
            failures <= errors;
            pending  <= expected_cmds.size();
        end
    end

endmodule

`default_nettype wire

[dv/ansi_escape_console_parser_tb.sv]
// Testbench top for the console parser: clock, reset, byte stimulus, receiver stalls and verdict.
`default_nettype none

module ansi_escape_console_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import acp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int STAGE_ITEMS = 480;
    localparam int RESTART_PCT = 2;

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_item;
    logic      cmd_valid;
    logic      cmd_stall;
    out_item_t cmd_item;

    int   failures;
    int   pending;
    int   stage;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   bytes_sent;
    logic hold_rx;

    ansi_escape_console_parser i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item)
    );

    console_cmd_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item),
        .failures   (failures),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Stage sets the idle mix: sender-light, receiver-light, then none
    always_comb
    begin
        case (stage)
            0:
            begin
                send_idle_pct = 15;
                recv_idle_pct = 51;
            end
            1:
            begin
                send_idle_pct = 51;
                recv_idle_pct = 15;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    end

    // Receiver stalls, changed at the falling edge
    initial
    begin
        cmd_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            cmd_stall <= hold_rx || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // One long hold-off on the result side so the block backs up into its input
    initial
    begin
        hold_rx = 1'b0;
        wait (stage == 2);
        repeat (40) @(posedge clk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("** ansi_escape_console_parser: FAILED **");
        $finish;
    end

    // Offer one byte item and wait until it is taken; starts and ends at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic new_msg, input logic [7:0] color);
        in_item_t it;
        it.text_byte   = b;
        it.first       = new_msg;
        it.start_color = color;
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Byte of the running stream, now and then restarting the message
    task automatic feed(input logic [7:0] b);
        send_byte(b, $urandom_range(99) < RESTART_PCT, 8'($urandom));
    endtask

    task automatic open_csi();
        feed(ASC_ESC);
        feed(ASC_LBRACKET);
    endtask

    task automatic feed_digits(input int n);
        repeat (n) feed(8'(ASC_ZERO + $urandom_range(9)));
    endtask

    function automatic logic [7:0] move_final();
        return 8'(ASC_UP_A + $urandom_range(3));
    endfunction

    // One random piece of console text: mostly well-formed sequences
    task automatic random_chunk();
        int pick;
        int ndig;
        pick = $urandom_range(99);
        if (pick < 35)
            feed(8'($urandom));
        else if (pick < 45)
        begin
            open_csi();
            case ($urandom_range(3))
                0:       feed(ASC_LO_S);
                1:       feed(ASC_LO_U);
                2:       feed(ASC_UP_K);
                default: feed(ASC_UP_H);
            endcase
        end
        else if (pick < 60)
        begin
            // cursor move, occasionally long enough to saturate
            ndig = ($urandom_range(9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
            open_csi();
            feed_digits(ndig);
            feed(move_final());
        end
        else if (pick < 66)
        begin
            open_csi();
            feed(ASC_QUESTION);
            feed(ASC_TWO);
            feed(8'(ASC_ZERO + 5));
            case ($urandom_range(3))
                0:       feed(ASC_LO_L);
                1:       feed(ASC_LO_H);
                default: feed(8'($urandom));
            endcase
        end
        else if (pick < 78)
        begin
            open_csi();
            case ($urandom_range(2))
                0:       feed(ASC_THREE);
                1:       feed(ASC_NINE);
                default: feed(ASC_FOUR);
            endcase
            feed({PARAM_HI_NIBBLE, 4'($urandom)});
            feed(ASC_LO_M);
        end
        else if (pick < 82)
        begin
            open_csi();
            feed(ASC_ZERO);
            feed(ASC_LO_M);
        end
        else if (pick < 86)
        begin
            open_csi();
            feed(ASC_TWO);
            feed(ASC_UP_J);
        end
        else
        begin
            // broken or odd sequences
            case ($urandom_range(3))
                0:
                begin
                    feed(ASC_ESC);
                    feed(8'($urandom));
                end
                1:
                begin
                    open_csi();
                    repeat ($urandom_range(0, 8)) feed({PARAM_HI_NIBBLE, 4'($urandom)});
                    feed(8'($urandom));
                end
                2:
                begin
                    open_csi();
                    feed_digits($urandom_range(1, 3));
                    open_csi();
                    feed_digits($urandom_range(0, 2));
                    feed(move_final());
                end
                default:
                begin
                    open_csi();
                    feed_digits(2);
                    send_byte(8'($urandom), 1'b1, 8'($urandom));
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_item  = '0;
        stage      = 0;
        bytes_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: field extremes and the special cases
        send_byte(8'h00, 1'b1, 8'h00);
        send_byte(8'hFF, 1'b0, 8'hFF);
        // saturating move count
        send_byte(ASC_ESC, 1'b0, 8'h00);
        send_byte(ASC_LBRACKET, 1'b0, 8'h00);
        repeat (5) send_byte(ASC_NINE, 1'b0, 8'h00);
        send_byte(ASC_UP_A, 1'b0, 8'h00);
        // ESC not followed by a bracket drops the next byte
        send_byte(ASC_ESC, 1'b0, 8'h00);
        send_byte(ASC_LO_S, 1'b0, 8'h00);
        // ESC inside an open sequence restarts it
        send_byte(ASC_ESC, 1'b0, 8'h00);
        send_byte(ASC_LBRACKET, 1'b0, 8'h00);
        send_byte(ASC_THREE, 1'b0, 8'h00);
        send_byte(ASC_ESC, 1'b0, 8'h00);
        send_byte(ASC_LBRACKET, 1'b0, 8'h00);
        send_byte(ASC_TWO, 1'b0, 8'h00);
        send_byte(ASC_UP_J, 1'b0, 8'h00);
        // new message in the middle of a sequence
        send_byte(ASC_ESC, 1'b0, 8'h00);
        send_byte(ASC_LBRACKET, 1'b0, 8'h00);
        send_byte(ASC_UP_B, 1'b1, 8'hFF);

        // Random stream over three idle mixes
        while (bytes_sent < STAGE_ITEMS)
            random_chunk();
        stage = 1;
        while (bytes_sent < 2 * STAGE_ITEMS)
            random_chunk();
        stage = 2;
        while (bytes_sent < 3 * STAGE_ITEMS)
            random_chunk();
        byte_valid <= 1'b0;

        // Drain, then allow for the pipeline latency
        wait (pending == 0);
        repeat (16) @(posedge clk);
        if (failures == 0)
            $display("** ansi_escape_console_parser: PASSED **");
        else
            $display("** ansi_escape_console_parser: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
